@@ src/wmb_pkg.sv @@
// ----------------------------------------------------------------------------
// wmb_pkg
// Shared types and constants for the weighted minimum bipartition engine.
// ----------------------------------------------------------------------------
package wmb_pkg;

    localparam int WEIGHT_IN_W = 16;
    localparam int ROW_IN_W    = 12;
    localparam int RESULT_W    = 40;
    localparam int TOTAL_W     = 4;

    localparam logic [RESULT_W-1:0] RESULT_MAX = {RESULT_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL_RD,
        ST_FILL_MUL,
        ST_FILL_WR,
        ST_MIN_RD,
        ST_MIN_CMP,
        ST_DONE
    } wmb_state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } wmb_tbl_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } wmb_status_t;

endpackage

@@ src/wmb_tables.sv @@
// ----------------------------------------------------------------------------
// wmb_tables
// Subset weight-sum and inner-weight memories: one write port, two read
// ports each, registered read data. Entry zero always reads as zero.
// ----------------------------------------------------------------------------
module wmb_tables
    import wmb_pkg::*;
#(
    parameter int TBL_W = 12,
    parameter int SUM_W = 20
)
(
    input  logic                clk,
    input  wmb_tbl_ctrl_t       tbl_ctrl,
    input  logic [TBL_W-1:0]    addr_a,
    input  logic [TBL_W-1:0]    addr_b,
    input  logic [TBL_W-1:0]    wr_addr,
    input  logic [SUM_W-1:0]    wr_sum,
    input  logic [RESULT_W-1:0] wr_inner,
    output logic [SUM_W-1:0]    rd_sum_a,
    output logic [SUM_W-1:0]    rd_sum_b,
    output logic [RESULT_W-1:0] rd_inner_a,
    output logic [RESULT_W-1:0] rd_inner_b
);

    localparam int DEPTH = 1 << TBL_W;

    logic [SUM_W-1:0]    sum_mem   [DEPTH];
    logic [RESULT_W-1:0] inner_mem [DEPTH];

    logic [SUM_W-1:0]    sum_a_reg;
    logic [SUM_W-1:0]    sum_b_reg;
    logic [RESULT_W-1:0] inner_a_reg;
    logic [RESULT_W-1:0] inner_b_reg;
    logic                zero_a_reg;
    logic                zero_b_reg;

    always_ff @(posedge clk)
    begin
        if (tbl_ctrl.wr_en)
        begin
            sum_mem[wr_addr]   <= wr_sum;
            inner_mem[wr_addr] <= wr_inner;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_ctrl.rd_en)
        begin
            sum_a_reg   <= sum_mem[addr_a];
            sum_b_reg   <= sum_mem[addr_b];
            inner_a_reg <= inner_mem[addr_a];
            inner_b_reg <= inner_mem[addr_b];
            zero_a_reg  <= (addr_a == '0);
            zero_b_reg  <= (addr_b == '0);
        end
    end

    // empty subset
    assign rd_sum_a   = zero_a_reg ? '0 : sum_a_reg;
    assign rd_sum_b   = zero_b_reg ? '0 : sum_b_reg;
    assign rd_inner_a = zero_a_reg ? '0 : inner_a_reg;
    assign rd_inner_b = zero_b_reg ? '0 : inner_b_reg;

endmodule

@@ src/wmb_engine.sv @@
// ----------------------------------------------------------------------------
// wmb_engine
// Sequencer and datapath: builds both subset tables by read-modify-write,
// then sweeps the cuts with vertex zero fixed and keeps the least sum.
// ----------------------------------------------------------------------------
module wmb_engine
    import wmb_pkg::*;
#(
    parameter int MAX_VERTICES = 12,
    parameter int WB_W         = 16,
    parameter int SUM_W        = 20,
    parameter int CNT_W        = 4,
    parameter int VIDX_W       = 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    go,
    input  logic [CNT_W-1:0]        n_total,
    output logic [VIDX_W-1:0]       vtx_idx,
    input  logic [WB_W-1:0]         vtx_weight,
    input  logic [MAX_VERTICES-1:0] vtx_row,
    output wmb_tbl_ctrl_t           tbl_ctrl,
    output logic [MAX_VERTICES-1:0] addr_a,
    output logic [MAX_VERTICES-1:0] addr_b,
    output logic [MAX_VERTICES-1:0] wr_addr,
    output logic [SUM_W-1:0]        wr_sum,
    output logic [RESULT_W-1:0]     wr_inner,
    input  logic [SUM_W-1:0]        rd_sum_a,
    input  logic [SUM_W-1:0]        rd_sum_b,
    input  logic [RESULT_W-1:0]     rd_inner_a,
    input  logic [RESULT_W-1:0]     rd_inner_b,
    output wmb_status_t             status,
    output logic [RESULT_W-1:0]     best
);

    localparam int TBL_W  = MAX_VERTICES;
    localparam int PROD_W = WB_W + SUM_W;

    wmb_state_t state_reg, state_next;

    logic [TBL_W-1:0]    s_reg, s_next;
    logic [TBL_W-1:0]    t_reg, t_next;
    logic [TBL_W-1:0]    full_reg, full_next;
    logic [WB_W-1:0]     w_reg, w_next;
    logic [SUM_W-1:0]    sum_new_reg, sum_new_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [RESULT_W-1:0] best_reg, best_next;

    logic [TBL_W-1:0]    rest;
    logic [TBL_W-1:0]    side;
    logic [TBL_W:0]      full_ext;
    logic [RESULT_W:0]   pair_sum;
    logic [RESULT_W-1:0] pair_sat;
    logic [VIDX_W-1:0]   low_idx;

    // lowest set vertex of the current subset
    always_comb
    begin
        low_idx = '0;
        for (int i = TBL_W - 1; i >= 0; i--)
        begin
            if (s_reg[i])
            begin
                low_idx = VIDX_W'(i);
            end
        end
    end

    assign rest     = s_reg & (s_reg - 1'b1);
    assign side     = {t_reg[TBL_W-2:0], 1'b1} & full_reg;
    assign full_ext = ((TBL_W + 1)'(1) << n_total) - 1'b1;
    assign pair_sum = {1'b0, rd_inner_a} + {1'b0, rd_inner_b};
    assign pair_sat = pair_sum[RESULT_W] ? RESULT_MAX : pair_sum[RESULT_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        s_next       = s_reg;
        t_next       = t_reg;
        full_next    = full_reg;
        w_next       = w_reg;
        sum_new_next = sum_new_reg;
        prod_next    = prod_reg;
        best_next    = best_reg;
        tbl_ctrl     = '0;
        status       = '0;
        addr_a       = rest;
        addr_b       = vtx_row & rest;

        case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    full_next  = full_ext[TBL_W-1:0];
                    s_next     = TBL_W'(1);
                    state_next = ST_FILL_RD;
                end
            end
            ST_FILL_RD:
            begin
                status.busy    = 1'b1;
                tbl_ctrl.rd_en = 1'b1;
                w_next         = vtx_weight;
                state_next     = ST_FILL_MUL;
            end
            ST_FILL_MUL:
            begin
                status.busy  = 1'b1;
                sum_new_next = rd_sum_a + SUM_W'(w_reg);
                prod_next    = PROD_W'(w_reg) * PROD_W'(rd_sum_b);
                state_next   = ST_FILL_WR;
            end
            ST_FILL_WR:
            begin
                status.busy    = 1'b1;
                tbl_ctrl.wr_en = 1'b1;
                if (s_reg == full_reg)
                begin
                    t_next     = '0;
                    best_next  = RESULT_MAX;
                    state_next = ST_MIN_RD;
                end
                else
                begin
                    s_next     = s_reg + 1'b1;
                    state_next = ST_FILL_RD;
                end
            end
            ST_MIN_RD:
            begin
                status.busy    = 1'b1;
                tbl_ctrl.rd_en = 1'b1;
                addr_a         = side;
                addr_b         = full_reg ^ side;
                state_next     = ST_MIN_CMP;
            end
            ST_MIN_CMP:
            begin
                status.busy = 1'b1;
                if (pair_sat < best_reg)
                begin
                    best_next = pair_sat;
                end
                if (t_reg == (full_reg >> 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    t_next     = t_reg + 1'b1;
                    state_next = ST_MIN_RD;
                end
            end
            ST_DONE:
            begin
                status.busy = 1'b1;
                status.done = 1'b1;
                best_next   = RESULT_MAX;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign vtx_idx  = low_idx;
    assign wr_addr  = s_reg;
    assign wr_sum   = sum_new_reg;
    assign wr_inner = rd_inner_a + RESULT_W'(prod_reg);
    assign best     = best_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            best_reg  <= RESULT_MAX;
        end
        else
        begin
            state_reg <= state_next;
            best_reg  <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg       <= s_next;
        t_reg       <= t_next;
        full_reg    <= full_next;
        w_reg       <= w_next;
        sum_new_reg <= sum_new_next;
        prod_reg    <= prod_next;
    end

    // table writes land only on non-empty subsets of the loaded vertices
    assert property (@(posedge clk) disable iff (!rst_n)
        tbl_ctrl.wr_en |-> (wr_addr != '0) && ((wr_addr & ~full_reg) == '0))
    else $error("table write outside loaded subsets");

    // the running minimum never grows during the cut sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MIN_RD && $past(state_reg) == ST_MIN_CMP)
            |-> best_reg <= $past(best_reg))
    else $error("running minimum increased");

    // a result is followed by an idle engine with a cleared minimum
    assert property (@(posedge clk) disable iff (!rst_n)
        status.done |=> !status.busy && best_reg == RESULT_MAX)
    else $error("engine not released after result");

endmodule

@@ src/weighted_min_bipartition.sv @@
// ----------------------------------------------------------------------------
// weighted_min_bipartition
// Loads a vertex-weighted graph one vertex per transaction and reports the
// least monochromatic edge weight over all two-sided cuts.
// ----------------------------------------------------------------------------
// A vertex is taken whenever start is high and busy is low. The
// transaction flagged last_vertex raises busy while the sequencer does a
// read-modify-write of the subset tables for each subset, whose single write
// port carries one entry at a time, and then sweeps the cuts. The result is
// shown for exactly one cycle with done high and cannot be stalled; the block
// is ready for the next graph in the cycle after. Rows past MAX_VERTICES are
// dropped and reported through too_many_vertices.
// ----------------------------------------------------------------------------
module weighted_min_bipartition
    import wmb_pkg::*;
#(
    parameter int MAX_VERTICES = 12,
    parameter int WEIGHT_BITS  = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [WEIGHT_IN_W-1:0] vertex_weight,
    input  logic [ROW_IN_W-1:0]    neighbor_mask,
    input  logic                   last_vertex,
    output logic                   done,
    output logic [RESULT_W-1:0]    min_mono_weight,
    output logic [TOTAL_W-1:0]     vertex_total,
    output logic                   too_many_vertices
);

    localparam int TBL_W  = MAX_VERTICES;
    localparam int WB_W   = (WEIGHT_BITS < WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;
    localparam int SUM_W  = WB_W + $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int VIDX_W = $clog2(MAX_VERTICES);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;

    logic [WB_W-1:0]  wt_store  [MAX_VERTICES];
    logic [TBL_W-1:0] row_store [MAX_VERTICES];

    logic                      accept;
    logic                      go;
    logic                      room;
    logic [TBL_W+ROW_IN_W-1:0] row_ext;
    logic [CNT_W+TOTAL_W-1:0]  cnt_ext;

    logic [VIDX_W-1:0]   vtx_idx;
    wmb_tbl_ctrl_t       tbl_ctrl;
    wmb_status_t         status;
    logic [TBL_W-1:0]    addr_a;
    logic [TBL_W-1:0]    addr_b;
    logic [TBL_W-1:0]    wr_addr;
    logic [SUM_W-1:0]    wr_sum;
    logic [RESULT_W-1:0] wr_inner;
    logic [SUM_W-1:0]    rd_sum_a;
    logic [SUM_W-1:0]    rd_sum_b;
    logic [RESULT_W-1:0] rd_inner_a;
    logic [RESULT_W-1:0] rd_inner_b;

    assign accept  = start && !status.busy;
    assign go      = accept && last_vertex;
    assign room    = (count_reg < CNT_W'(MAX_VERTICES));
    assign row_ext = {{TBL_W{1'b0}}, neighbor_mask};

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (room)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (status.done)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // vertex rows, masked to the table width
    always_ff @(posedge clk)
    begin
        if (accept && room)
        begin
            wt_store[count_reg[VIDX_W-1:0]]  <= vertex_weight[WB_W-1:0];
            row_store[count_reg[VIDX_W-1:0]] <= row_ext[TBL_W-1:0];
        end
    end

    wmb_engine #(
        .MAX_VERTICES (MAX_VERTICES),
        .WB_W         (WB_W),
        .SUM_W        (SUM_W),
        .CNT_W        (CNT_W),
        .VIDX_W       (VIDX_W)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .n_total    (count_next),
        .vtx_idx    (vtx_idx),
        .vtx_weight (wt_store[vtx_idx]),
        .vtx_row    (row_store[vtx_idx]),
        .tbl_ctrl   (tbl_ctrl),
        .addr_a     (addr_a),
        .addr_b     (addr_b),
        .wr_addr    (wr_addr),
        .wr_sum     (wr_sum),
        .wr_inner   (wr_inner),
        .rd_sum_a   (rd_sum_a),
        .rd_sum_b   (rd_sum_b),
        .rd_inner_a (rd_inner_a),
        .rd_inner_b (rd_inner_b),
        .status     (status),
        .best       (min_mono_weight)
    );

    wmb_tables #(
        .TBL_W (TBL_W),
        .SUM_W (SUM_W)
    ) u_tables (
        .clk        (clk),
        .tbl_ctrl   (tbl_ctrl),
        .addr_a     (addr_a),
        .addr_b     (addr_b),
        .wr_addr    (wr_addr),
        .wr_sum     (wr_sum),
        .wr_inner   (wr_inner),
        .rd_sum_a   (rd_sum_a),
        .rd_sum_b   (rd_sum_b),
        .rd_inner_a (rd_inner_a),
        .rd_inner_b (rd_inner_b)
    );

    assign cnt_ext           = {{TOTAL_W{1'b0}}, count_reg};
    assign busy              = status.busy;
    assign done              = status.done;
    assign vertex_total      = cnt_ext[TOTAL_W-1:0];
    assign too_many_vertices = ovf_reg;

    // last vertex transaction always starts the engine
    assert property (@(posedge clk) disable iff (!rst_n)
        go |=> busy && count_reg != '0)
    else $error("engine not started by last vertex");

    // vertex count stays fixed while the engine runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !done) |=> $stable(count_reg))
    else $error("vertex count changed while busy");

    // overflow only with a full vertex store
    assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> count_reg == CNT_W'(MAX_VERTICES))
    else $error("overflow flagged with room left");

endmodule
